FILE: hdl/rtg_pkg.sv
// Shared types, constants and gamma knot functions for the tone map core.
package rtg_pkg;

	localparam int NCH        = 3;
	localparam int CH_W       = 24;
	localparam int W_W        = 16;
	localparam int W_FRAC     = 16;
	localparam int OUT_W      = 16;
	localparam int PROD_W     = W_W + CH_W + 1;
	localparam int LSUM_W     = PROD_W + 2;
	localparam int DEN_W      = 27;
	localparam int Q_W        = 24;
	localparam int DIV_BITS   = 2;
	localparam int DIV_STAGES = Q_W / DIV_BITS;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RED_WEIGHT   = 2'd0,
		CFG_GREEN_WEIGHT = 2'd1,
		CFG_BLUE_WEIGHT  = 2'd2
	} cfg_idx_t;

	typedef logic [NCH-1:0][W_W-1:0]   weights_t;
	typedef logic [NCH-1:0][CH_W-1:0]  chan_t;
	typedef logic [NCH-1:0][Q_W-1:0]   quo_t;
	typedef logic [NCH-1:0][OUT_W-1:0] pix_t;

	localparam weights_t WEIGHT_RST = {16'd4588, 16'd47186, 16'd13763};

	typedef struct packed {
		logic [DEN_W-1:0] den;
		chan_t            chan;
	} lum_word_t;

	typedef struct packed {
		pix_t chan;
		logic over;
	} res_t;

	typedef struct packed {
		logic [31:0]        m;
		logic signed [31:0] e;
	} sfnum_t;

	function automatic sfnum_t sf_of(logic [31:0] v);
		sfnum_t r;
		r.m = v;
		r.e = '0;
		if (v != '0) begin
			for (int i = 0; i < 31; i++) begin
				if (!r.m[31]) begin
					r.m = r.m << 1;
					r.e = r.e - 32'sd1;
				end
			end
		end
		return r;
	endfunction

	function automatic sfnum_t sf_mul(sfnum_t a, sfnum_t b);
		sfnum_t      r;
		logic [63:0] p;
		if (a.m == '0 || b.m == '0) begin
			r.m = '0;
			r.e = '0;
		end else begin
			p = {32'd0, a.m} * {32'd0, b.m};
			if (p[63]) begin
				r.m = p[63:32];
				r.e = a.e + b.e + 32'sd32;
			end else begin
				r.m = p[62:31];
				r.e = a.e + b.e + 32'sd31;
			end
		end
		return r;
	endfunction

	function automatic sfnum_t sf_pow(sfnum_t a, int n);
		sfnum_t r;
		r = sf_of(32'd1);
		for (int i = 0; i < n; i++) begin
			r = sf_mul(r, a);
		end
		return r;
	endfunction

	function automatic logic sf_le(sfnum_t a, sfnum_t b);
		logic res;
		if (a.m == '0) res = 1'b1;
		else if (b.m == '0) res = 1'b0;
		else if (a.e != b.e) res = (a.e < b.e);
		else res = (a.m <= b.m);
		return res;
	endfunction

	// largest y with y^11 * 2^(5g) <= k^5 * 65535^11
	function automatic logic [OUT_W-1:0] gamma_knot(logic [31:0] k, int gbits);
		sfnum_t      full11;
		sfnum_t      rhs;
		sfnum_t      lhs;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] mid;
		full11 = sf_pow(sf_of(32'd65535), 11);
		rhs    = sf_mul(sf_pow(sf_of(k), 5), full11);
		lo     = 32'd0;
		hi     = 32'd65535;
		for (int i = 0; i < 17; i++) begin
			if (lo < hi) begin
				mid = (lo + hi + 32'd1) >> 1;
				lhs = sf_pow(sf_of(mid), 11);
				if (lhs.m != '0) lhs.e = lhs.e + 32'(5 * gbits);
				if (sf_le(lhs, rhs)) lo = mid;
				else hi = mid - 32'd1;
			end
		end
		return OUT_W'(lo);
	endfunction

endpackage

FILE: hdl/rtg_pix_in_if.sv
// Input pixel channel: valid, ready and the three linear channels.
interface rtg_pix_in_if;
	import rtg_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red_in;
	logic [CH_W-1:0] green_in;
	logic [CH_W-1:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in, input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

FILE: hdl/rtg_pix_out_if.sv
// Output pixel channel: valid, ready, encoded channels and saturation flag.
interface rtg_pix_out_if;
	import rtg_pkg::*;

	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] red_out;
	logic [OUT_W-1:0] green_out;
	logic [OUT_W-1:0] blue_out;
	logic             over_range;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output over_range, input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		input over_range, output ready);
endinterface

FILE: hdl/rtg_lum.sv
// Luminance stages: weighted products, then sum and divisor 1 + L.
module rtg_lum #(
	parameter int FRACTION_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rtg_pkg::weights_t weights,
	input  logic              in_valid,
	output logic              in_ready,
	input  rtg_pkg::chan_t    in_chan,
	output logic              out_valid,
	input  logic              out_ready,
	output rtg_pkg::lum_word_t out_word
);
	import rtg_pkg::*;

	localparam logic [CH_W:0] EPS_Q =
		(CH_W+1)'(((64'd1 << FRACTION_BITS) + 64'd5000) / 64'd10000);
	localparam logic [DEN_W-1:0] ONE_DEN = DEN_W'(64'd1 << FRACTION_BITS);

	logic                          v_s1;
	logic                          v_s2;
	logic                          rdy_s1;
	logic                          rdy_s2;
	logic [NCH-1:0][PROD_W-1:0]    prod_s1;
	chan_t                         chan_s1;
	logic [NCH-1:0][PROD_W-1:0]    prod_n;
	logic [LSUM_W-1:0]             lsum;
	logic [DEN_W-1:0]              den_n;

	assign rdy_s2    = !v_s2 || out_ready;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign in_ready  = rdy_s1;
	assign out_valid = v_s2;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			prod_n[c] = PROD_W'(weights[c]) * PROD_W'({1'b0, in_chan[c]} + EPS_Q);
		end
		lsum  = LSUM_W'(prod_s1[0]) + LSUM_W'(prod_s1[1]) + LSUM_W'(prod_s1[2]);
		den_n = DEN_W'(lsum >> W_FRAC) + ONE_DEN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			prod_s1 <= prod_n;
			chan_s1 <= in_chan;
		end
		if (rdy_s2 && v_s1) begin
			out_word.den  <= den_n;
			out_word.chan <= chan_s1;
		end
	end
endmodule

FILE: hdl/rtg_div.sv
// Pipelined restoring divider: scaled channel = round(c * 2^F / den).
module rtg_div #(
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rtg_pkg::lum_word_t in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output rtg_pkg::quo_t      out_quo
);
	import rtg_pkg::*;

	localparam int NSTG = DIV_STAGES;
	localparam int NUM_W = CH_W + FRACTION_BITS + 1;

	logic [NSTG:0]                     v_s;
	logic [NSTG:0]                     rdy;
	logic [DEN_W-1:0]                  den_s [NSTG+1];
	logic [NCH-1:0][DEN_W-1:0]         rem_s [NSTG+1];
	logic [NCH-1:0][Q_W-1:0]           low_s [NSTG+1];
	logic [NCH-1:0][Q_W-1:0]           quo_s [NSTG+1];
	logic [NCH-1:0][DEN_W-1:0]         rem_n [NSTG+1];
	logic [NCH-1:0][Q_W-1:0]           low_n [NSTG+1];
	logic [NCH-1:0][Q_W-1:0]           quo_n [NSTG+1];

	for (genvar k = 0; k <= NSTG; k++) begin : g_rdy
		if (k == NSTG) begin : g_last
			assign rdy[k] = out_ready || !v_s[k];
		end else begin : g_mid
			assign rdy[k] = out_ready || !(&v_s[NSTG:k]);
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = v_s[NSTG];
	assign out_quo   = quo_s[NSTG];

	always_comb begin
		logic [NUM_W-1:0] num;
		logic [DEN_W:0]   t;
		logic [DEN_W-1:0] r;
		logic [Q_W-1:0]   l;
		logic [Q_W-1:0]   q;
		for (int c = 0; c < NCH; c++) begin
			num = (NUM_W'(in_word.chan[c]) << FRACTION_BITS) + NUM_W'(in_word.den >> 1);
			rem_n[0][c] = DEN_W'(num >> Q_W);
			low_n[0][c] = num[Q_W-1:0];
			quo_n[0][c] = '0;
		end
		for (int k = 1; k <= NSTG; k++) begin
			for (int c = 0; c < NCH; c++) begin
				r = rem_s[k-1][c];
				l = low_s[k-1][c];
				q = quo_s[k-1][c];
				for (int b = 0; b < DIV_BITS; b++) begin
					t = {r, l[Q_W-1]};
					l = l << 1;
					if (t >= {1'b0, den_s[k-1]}) begin
						r = DEN_W'(t - {1'b0, den_s[k-1]});
						q = {q[Q_W-2:0], 1'b1};
					end else begin
						r = t[DEN_W-1:0];
						q = {q[Q_W-2:0], 1'b0};
					end
				end
				rem_n[k][c] = r;
				low_n[k][c] = l;
				quo_n[k][c] = q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (rdy[0]) v_s[0] <= in_valid;
			for (int k = 1; k <= NSTG; k++) begin
				if (rdy[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			den_s[0] <= in_word.den;
			rem_s[0] <= rem_n[0];
			low_s[0] <= low_n[0];
			quo_s[0] <= quo_n[0];
		end
		for (int k = 1; k <= NSTG; k++) begin
			if (rdy[k] && v_s[k-1]) begin
				den_s[k] <= den_s[k-1];
				rem_s[k] <= rem_n[k];
				low_s[k] <= low_n[k];
				quo_s[k] <= quo_n[k];
			end
		end
	end
endmodule

FILE: hdl/rtg_gamma.sv
// Saturation, gamma knot lookup and linear interpolation between knots.
module rtg_gamma #(
	parameter int FRACTION_BITS    = 16,
	parameter int GAMMA_INDEX_BITS = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rtg_pkg::quo_t in_quo,
	output logic          out_valid,
	input  logic          out_ready,
	output rtg_pkg::res_t out_res
);
	import rtg_pkg::*;

	localparam int TBL_LEN = (1 << GAMMA_INDEX_BITS) + 1;
	localparam int IDX_W   = GAMMA_INDEX_BITS + 1;
	localparam int S_W     = FRACTION_BITS + 1;
	localparam int DOWN    = (FRACTION_BITS > GAMMA_INDEX_BITS) ?
		FRACTION_BITS - GAMMA_INDEX_BITS : 0;
	localparam int UP      = (GAMMA_INDEX_BITS > FRACTION_BITS) ?
		GAMMA_INDEX_BITS - FRACTION_BITS : 0;
	localparam int FR_W    = (DOWN > 0) ? DOWN : 1;
	localparam int IP_W    = OUT_W + FR_W;
	localparam logic [IP_W:0] HALF = (DOWN > 0) ? (IP_W+1)'(1 << (FR_W - 1)) : '0;
	localparam logic [Q_W:0]  ONE_Q = (Q_W+1)'(64'd1 << FRACTION_BITS);

	typedef logic [2*OUT_W-1:0] rom_t [TBL_LEN];

	function automatic rom_t build_rom();
		rom_t             r;
		logic [OUT_W-1:0] kn [TBL_LEN];
		for (int k = 0; k < TBL_LEN; k++) begin
			kn[k] = gamma_knot(32'(k), GAMMA_INDEX_BITS);
		end
		for (int k = 0; k < TBL_LEN; k++) begin
			r[k] = {(k + 1 < TBL_LEN) ? kn[k+1] : kn[k], kn[k]};
		end
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	logic                        v_s1;
	logic                        v_s2;
	logic                        v_s3;
	logic                        rdy_s1;
	logic                        rdy_s2;
	logic                        rdy_s3;
	logic [NCH-1:0]              sat;
	logic [NCH-1:0][IDX_W-1:0]   addr;
	logic [NCH-1:0][FR_W-1:0]    fr_n;
	logic [NCH-1:0][2*OUT_W-1:0] pair_s1;
	logic [NCH-1:0][FR_W-1:0]    fr_s1;
	logic                        over_s1;
	logic [NCH-1:0][OUT_W-1:0]   y0_s2;
	logic [NCH-1:0][IP_W-1:0]    ip_s2;
	logic                        over_s2;
	logic [NCH-1:0][OUT_W-1:0]   diff;
	pix_t                        pix_n;

	assign rdy_s3    = !v_s3 || out_ready;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign in_ready  = rdy_s1;
	assign out_valid = v_s3;

	always_comb begin
		logic [Q_W:0]   qx;
		logic [S_W-1:0] s;
		logic [IP_W:0]  rnd;
		for (int c = 0; c < NCH; c++) begin
			qx      = {1'b0, in_quo[c]};
			sat[c]  = qx > ONE_Q;
			s       = sat[c] ? ONE_Q[S_W-1:0] : qx[S_W-1:0];
			addr[c] = IDX_W'((32'(s) >> DOWN) << UP);
			fr_n[c] = (DOWN > 0) ? FR_W'(s) : '0;
			diff[c] = (pair_s1[c][2*OUT_W-1:OUT_W] > pair_s1[c][OUT_W-1:0]) ?
				pair_s1[c][2*OUT_W-1:OUT_W] - pair_s1[c][OUT_W-1:0] : '0;
			rnd      = (IP_W+1)'(ip_s2[c]) + HALF;
			pix_n[c] = OUT_W'({1'b0, y0_s2[c]} + (OUT_W+1)'(rnd >> DOWN));
		end
	end

	for (genvar c = 0; c < NCH; c++) begin : g_rom
		localparam rom_t ROM_CH = ROM;
		always_ff @(posedge clk) begin
			if (rdy_s1 && in_valid) pair_s1[c] <= ROM_CH[addr[c]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			fr_s1   <= fr_n;
			over_s1 <= |sat;
		end
		if (rdy_s2 && v_s1) begin
			for (int c = 0; c < NCH; c++) begin
				y0_s2[c] <= pair_s1[c][OUT_W-1:0];
				ip_s2[c] <= IP_W'(diff[c]) * IP_W'(fr_s1[c]);
			end
			over_s2 <= over_s1;
		end
		if (rdy_s3 && v_s2) begin
			out_res.chan <= pix_n;
			out_res.over <= over_s2;
		end
	end
endmodule

FILE: hdl/reinhard_tone_map_gamma_core.sv
// Top level: global Reinhard tone mapping with gamma 2.2 encoding, one pixel a word.
//
// Usage:
//   in  : valid/ready channel of linear RGB pixels, unsigned Q8.16 per channel.
//   out : valid/ready channel of gamma encoded Q0.16 channels plus over_range,
//         which is set when any channel scaled by 1/(1+L) exceeded 1.0.
//   cfg : write-only port for the red, green and blue luminance weights (Q0.16).
//         Write the weights only while no pixel is in flight.
// From input word to output word a pixel passes 2 luminance stages,
// 1 numerator stage and 12 divider stages (2 quotient bits each), then
// 3 gamma stages (table read, interpolation product, rounding add).
// One pixel per clock unless out stalls; every stage holds its own valid bit.
// When the receiver stalls, the output register holds its word and earlier
// stages keep filling until every stage is full; only then does in.ready drop.
// Reset clears all valid bits and loads the default weights 0.21, 0.72, 0.07.
// The gamma knot table is a ROM built at elaboration; no clearing pass.
module reinhard_tone_map_gamma_core #(
	parameter int FRACTION_BITS    = 16,
	parameter int GAMMA_INDEX_BITS = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	rtg_pix_in_if.sink                       in,
	rtg_pix_out_if.source                    out,
	input  logic                             cfg_wr_en,
	input  logic [rtg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rtg_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import rtg_pkg::*;

	weights_t  weights_q;
	chan_t     in_chan;
	logic      lum_valid;
	logic      lum_ready;
	lum_word_t lum_word;
	logic      div_valid;
	logic      div_ready;
	quo_t      div_quo;
	res_t      res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_q <= WEIGHT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_RED_WEIGHT:   weights_q[0] <= W_W'(cfg_data);
				CFG_GREEN_WEIGHT: weights_q[1] <= W_W'(cfg_data);
				CFG_BLUE_WEIGHT:  weights_q[2] <= W_W'(cfg_data);
				default:          weights_q    <= weights_q;
			endcase
		end
	end

	assign in_chan = {in.blue_in, in.green_in, in.red_in};

	rtg_lum #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_lum (
		.clk       (clk),
		.arst_n    (arst_n),
		.weights   (weights_q),
		.in_valid  (in.valid),
		.in_ready  (in.ready),
		.in_chan   (in_chan),
		.out_valid (lum_valid),
		.out_ready (lum_ready),
		.out_word  (lum_word)
	);

	rtg_div #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (lum_valid),
		.in_ready  (lum_ready),
		.in_word   (lum_word),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_quo   (div_quo)
	);

	rtg_gamma #(
		.FRACTION_BITS    (FRACTION_BITS),
		.GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
	) u_gamma (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_quo    (div_quo),
		.out_valid (out.valid),
		.out_ready (out.ready),
		.out_res   (res)
	);

	assign out.red_out    = res.chan[0];
	assign out.green_out  = res.chan[1];
	assign out.blue_out   = res.chan[2];
	assign out.over_range = res.over;

	a_sat_full_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(out.valid && out.over_range) |->
		(out.red_out == 16'hFFFF || out.green_out == 16'hFFFF || out.blue_out == 16'hFFFF))
		else $error("saturated pixel without a full scale channel");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in.ready |-> (out.valid && !out.ready))
		else $error("input blocked while the output is not stalled");

	a_div_ready_on_gap: assert property (@(posedge clk) disable iff (!arst_n)
		!lum_ready |-> !div_ready)
		else $error("divider stalls while the gamma stage accepts");
endmodule
